### src/bounded_list_with_positional_delete_defines.svh
// assertion macros for the bounded list block
`ifndef BOUNDED_LIST_WITH_POSITIONAL_DELETE_DEFINES_SVH
`define BOUNDED_LIST_WITH_POSITIONAL_DELETE_DEFINES_SVH

// invariant checked at every rising clock edge outside reset
`define BLPD_ASSERT_ALWAYS(lbl, clk_s, rst_n_s, expr, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (expr)) else $error(msg);

// condition in one cycle implies a consequence in the next
`define BLPD_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) else $error(msg);

`endif

### src/blpd_pkg.sv
// shared types, codes and constants of the bounded list block
`timescale 1ns / 1ps
package blpd_pkg;
	localparam int DATA_W = 32;
	localparam int CMD_W = 3;
	localparam int POS_W = 6;
	localparam int STAT_W = 2;
	localparam int DEF_CAPACITY = 16;

	typedef logic [CMD_W-1:0] cmd_t;
	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [POS_W-1:0] pos_t;
	typedef logic [STAT_W-1:0] stat_t;

	localparam cmd_t CMD_APPEND = 3'd0;
	localparam cmd_t CMD_DEL_HEAD = 3'd1;
	localparam cmd_t CMD_DEL_TAIL = 3'd2;
	localparam cmd_t CMD_DEL_POS = 3'd3;
	localparam cmd_t CMD_READ_ALL = 3'd4;

	localparam stat_t STAT_OK = 2'd0;
	localparam stat_t STAT_EMPTY = 2'd1;
	localparam stat_t STAT_NOT_FOUND = 2'd2;
	localparam stat_t STAT_FULL = 2'd3;

	typedef struct packed {
		logic load;
		logic shift;
		logic sel;
	} cell_ctrl_t;
endpackage

### src/blpd_cmd_if.sv
// request channel: command, value and position with valid/ready
`timescale 1ns / 1ps
interface blpd_cmd_if import blpd_pkg::*; ();
	logic valid;
	logic ready;
	cmd_t command;
	data_t value;
	pos_t position;

	modport source (output valid, output command, output value, output position, input ready);
	modport sink (input valid, input command, input value, input position, output ready);
endinterface

### src/blpd_rsp_if.sv
// result channel: status, value, index and last mark with valid/ready
`timescale 1ns / 1ps
interface blpd_rsp_if import blpd_pkg::*; ();
	logic valid;
	logic ready;
	stat_t status;
	data_t value_res;
	pos_t index;
	logic last;

	modport source (output valid, output status, output value_res, output index, output last,
		input ready);
	modport sink (input valid, input status, input value_res, input index, input last,
		output ready);
endinterface

### src/bounded_list_with_positional_delete.sv
// top level of the bounded list: cell chain, command control and result register
//
// channel | dir | payload                              | handshake
// cmd     | in  | command, value, position             | valid/ready
// rsp     | out | status, value_res, index, last       | valid/ready
//
// append and deletes: one request per cycle while the result register is free, result registered the cycle after
// read all: one result per held element, one per cycle, paced by the result register
// deletes close the gap by shifting every cell above the target
// cmd.ready is low while read all runs and while an unread result blocks the register
// reset clears the element count and control; cell contents are left as they are
`timescale 1ns / 1ps
`include "bounded_list_with_positional_delete_defines.svh"
module bounded_list_with_positional_delete import blpd_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input logic clk,
	input logic arst_n,
	blpd_cmd_if.sink cmd,
	blpd_rsp_if.source rsp
);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int RD_W = $clog2(CAPACITY);
	localparam int EXT_W = POS_W + 1;
	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q;
	logic [CNT_W-1:0] count_q;
	logic [RD_W-1:0] rd_q;
	logic rsp_valid_q;
	stat_t status_q;
	data_t value_q;
	pos_t index_q;
	logic last_q;

	logic out_free, acc, empty, full, del_cmd, del_ok, app_ok, rd_last;
	logic [EXT_W-1:0] count_x, pos_x, rd_x, tgt;
	cell_ctrl_t ctrl [CAPACITY];
	data_t cell_data [CAPACITY];
	data_t sel_data [CAPACITY];
	data_t rd_data;

	logic rsp_load;
	stat_t status_d;
	data_t value_d;
	pos_t index_d;
	logic last_d;
	logic start_read;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE) && out_free;
	assign acc = cmd.valid && cmd.ready;

	assign count_x = EXT_W'(count_q);
	assign pos_x = EXT_W'(cmd.position);
	assign rd_x = EXT_W'(rd_q);
	assign empty = (count_q == '0);
	assign full = (count_x == EXT_W'(CAPACITY));
	assign rd_last = (rd_x == count_x - EXT_W'(1));

	always_comb begin
		tgt = '0;
		del_cmd = 1'b0;
		if (state_q == S_READ) begin
			tgt = rd_x;
		end else begin
			case (cmd.command)
				CMD_DEL_HEAD: begin
					tgt = '0;
					del_cmd = 1'b1;
				end
				CMD_DEL_TAIL: begin
					tgt = count_x - EXT_W'(1);
					del_cmd = 1'b1;
				end
				CMD_DEL_POS: begin
					tgt = pos_x;
					del_cmd = 1'b1;
				end
				default: begin
					tgt = '0;
					del_cmd = 1'b0;
				end
			endcase
		end
	end

	assign del_ok = acc && del_cmd && !empty && (tgt < count_x);
	assign app_ok = acc && (cmd.command == CMD_APPEND) && !full;

	// chain of cells, each at or above the target but the top one taking its upper neighbor on a delete
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign ctrl[i].load = app_ok && (EXT_W'(i) == count_x);
		assign ctrl[i].shift = del_ok && (EXT_W'(i) >= tgt) && (i < CAPACITY - 1);
		assign ctrl[i].sel = (EXT_W'(i) == tgt);

		blpd_cell u_cell (
			.clk (clk),
			.ctrl (ctrl[i]),
			.new_data (cmd.value),
			.next_data (cell_data[(i < CAPACITY - 1) ? i + 1 : i]),
			.data (cell_data[i]),
			.sel_data (sel_data[i])
		);
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_data = rd_data | sel_data[i];
		end
	end

	always_comb begin
		rsp_load = 1'b0;
		start_read = 1'b0;
		status_d = STAT_OK;
		value_d = '0;
		index_d = '0;
		last_d = 1'b1;
		if (state_q == S_READ) begin
			if (out_free) begin
				rsp_load = 1'b1;
				value_d = rd_data;
				index_d = POS_W'(rd_x);
				last_d = rd_last;
			end
		end else if (acc) begin
			case (cmd.command)
				CMD_APPEND: begin
					rsp_load = 1'b1;
					if (full) begin
						status_d = STAT_FULL;
					end else begin
						value_d = cmd.value;
						index_d = POS_W'(count_x);
					end
				end
				CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
					rsp_load = 1'b1;
					if (empty) begin
						status_d = STAT_EMPTY;
					end else if (!del_ok) begin
						status_d = STAT_NOT_FOUND;
						index_d = cmd.position;
					end else begin
						value_d = rd_data;
						index_d = POS_W'(tgt);
					end
				end
				CMD_READ_ALL: begin
					if (empty) begin
						rsp_load = 1'b1;
						status_d = STAT_EMPTY;
					end else begin
						start_read = 1'b1;
					end
				end
				default: begin
					rsp_load = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			rd_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (app_ok) begin
				count_q <= count_q + CNT_W'(1);
			end else if (del_ok) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (start_read) begin
				state_q <= S_READ;
				rd_q <= '0;
			end else if (state_q == S_READ && out_free) begin
				rd_q <= rd_q + RD_W'(1);
				if (rd_last) begin
					state_q <= S_IDLE;
				end
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status_q <= status_d;
			value_q <= value_d;
			index_q <= index_d;
			last_q <= last_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.value_res = value_q;
	assign rsp.index = index_q;
	assign rsp.last = last_q;

	`BLPD_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_x <= EXT_W'(CAPACITY), "count over capacity")
	`BLPD_ASSERT_ALWAYS(a_read_in_range, clk, arst_n, (state_q != S_READ) || (rd_x < count_x), "read index out of range")
	`BLPD_ASSERT_NEXT(a_append_count, clk, arst_n, app_ok, count_q == $past(count_q) + CNT_W'(1), "append did not grow list")
	`BLPD_ASSERT_NEXT(a_delete_count, clk, arst_n, del_ok, count_q == $past(count_q) - CNT_W'(1), "delete did not shrink list")
endmodule

### src/blpd_cell.sv
// one list cell: holds an element, loads new data or takes its neighbor's
`timescale 1ns / 1ps
module blpd_cell import blpd_pkg::*; (
	input logic clk,
	input cell_ctrl_t ctrl,
	input data_t new_data,
	input data_t next_data,
	output data_t data,
	output data_t sel_data
);
	data_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			data_q <= new_data;
		end else if (ctrl.shift) begin
			data_q <= next_data;
		end
	end

	assign data = data_q;
	assign sel_data = ctrl.sel ? data_q : '0;
endmodule

### test/bounded_list_with_positional_delete_checker.sv
// checker for the bounded list: tracks the list contents from accepted requests and compares every result
`timescale 1ns / 1ps
module bounded_list_with_positional_delete_checker import blpd_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input logic clk,
	input logic arst_n,
	blpd_cmd_if cmd,
	blpd_rsp_if rsp,
	input logic end_check,
	output int fail_count,
	output int open_count,
	output int results_checked,
	output int empty_hits,
	output int not_found_hits,
	output int full_hits
);
	typedef struct packed {
		stat_t status;
		data_t value_res;
		pos_t index;
		logic last;
	} list_result_t;

	list_result_t expected_q[$];
	list_result_t oldest;
	data_t shadow_cells [CAPACITY];
	int shadow_count;
	int mismatches;
	int checked;
	int n_empty;
	int n_not_found;
	int n_full;
	bit leftover_reported;

	task automatic report_mismatch(input string msg);
		$display("%0t list check: %s", $time, msg);
		mismatches++;
	endtask

	task automatic push_result(input stat_t s, input data_t v, input pos_t i, input logic l);
		list_result_t r;
		r.status = s;
		r.value_res = v;
		r.index = i;
		r.last = l;
		expected_q.push_back(r);
	endtask

	task automatic predict_list_op(input cmd_t c, input data_t v, input pos_t p);
		int at;
		data_t removed;
		case (c)
			CMD_APPEND: begin
				if (shadow_count >= CAPACITY) begin
					push_result(STAT_FULL, '0, '0, 1'b1);
				end else begin
					shadow_cells[shadow_count] = v;
					push_result(STAT_OK, v, pos_t'(shadow_count), 1'b1);
					shadow_count++;
				end
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_POS: begin
				if (shadow_count == 0) begin
					push_result(STAT_EMPTY, '0, '0, 1'b1);
				end else if (c == CMD_DEL_POS && int'(p) >= shadow_count) begin
					push_result(STAT_NOT_FOUND, '0, p, 1'b1);
				end else begin
					if (c == CMD_DEL_HEAD)
						at = 0;
					else if (c == CMD_DEL_TAIL)
						at = shadow_count - 1;
					else
						at = int'(p);
					removed = shadow_cells[at];
					for (int k = at; k < shadow_count - 1; k++)
						shadow_cells[k] = shadow_cells[k + 1];
					shadow_count--;
					push_result(STAT_OK, removed, pos_t'(at), 1'b1);
				end
			end
			CMD_READ_ALL: begin
				if (shadow_count == 0) begin
					push_result(STAT_EMPTY, '0, '0, 1'b1);
				end else begin
					for (int k = 0; k < shadow_count; k++)
						push_result(STAT_OK, shadow_cells[k], pos_t'(k), k == shadow_count - 1);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q.delete();
			shadow_count = 0;
			mismatches = 0;
			checked = 0;
			n_empty = 0;
			n_not_found = 0;
			n_full = 0;
			leftover_reported = 1'b0;
			fail_count <= 0;
			open_count <= 0;
			results_checked <= 0;
			empty_hits <= 0;
			not_found_hits <= 0;
			full_hits <= 0;
		end else begin
			// results first: a request never yields a result at the edge it is taken
			if (rsp.valid && rsp.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d value %0d index %0d last %0d",
						rsp.status, rsp.value_res, rsp.index, rsp.last));
				end else begin
					oldest = expected_q.pop_front();
					checked++;
					case (oldest.status)
						STAT_EMPTY: n_empty++;
						STAT_NOT_FOUND: n_not_found++;
						STAT_FULL: n_full++;
						default: ;
					endcase
					if (rsp.status !== oldest.status || rsp.value_res !== oldest.value_res ||
						rsp.index !== oldest.index || rsp.last !== oldest.last)
						report_mismatch($sformatf(
							"result %0d got status %0d value %0d index %0d last %0d, want %0d %0d %0d %0d",
							checked, rsp.status, rsp.value_res, rsp.index, rsp.last,
							oldest.status, oldest.value_res, oldest.index, oldest.last));
				end
			end
			if (cmd.valid && cmd.ready)
				predict_list_op(cmd.command, cmd.value, cmd.position);
			if (end_check && !leftover_reported && expected_q.size() != 0) begin
				report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
				leftover_reported = 1'b1;
			end
			fail_count <= mismatches;
			open_count <= expected_q.size();
			results_checked <= checked;
			empty_hits <= n_empty;
			not_found_hits <= n_not_found;
			full_hits <= n_full;
		end
	end
endmodule

### test/bounded_list_with_positional_delete_tb.sv
// testbench top for the bounded list: stimulus, result-side stalls, watchdog and verdict
`timescale 1ns / 1ps
module bounded_list_with_positional_delete_tb import blpd_pkg::*; ();
	localparam int CAPACITY = DEF_CAPACITY;
	localparam int ROUNDS = 7;
	localparam int ROUND_ITEMS = 25;
	localparam int LONG_HOLD = 300;
	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 20;
	localparam int FIRST_UNUSED_CMD = int'(CMD_READ_ALL) + 1;
	localparam int LAST_CMD = (1 << CMD_W) - 1;

	typedef enum int {
		MODE_FILL,
		MODE_MIX,
		MODE_DRAIN
	} traffic_mode_t;

	typedef enum int {
		RX_OPEN,
		RX_RANDOM,
		RX_SPARSE
	} rx_mode_t;

	logic clk;
	logic arst_n;
	logic end_check;
	int fail_count;
	int open_count;
	int results_checked;
	int empty_hits;
	int not_found_hits;
	int full_hits;
	int requests_sent;
	int ignored_sent;
	int hold_requests;
	int holds_done;
	int idle_cycles;

	blpd_cmd_if cmd_ch ();
	blpd_rsp_if rsp_ch ();

	bounded_list_with_positional_delete #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	bounded_list_with_positional_delete_checker #(
		.CAPACITY(CAPACITY)
	) list_check (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.end_check(end_check),
		.fail_count(fail_count),
		.open_count(open_count),
		.results_checked(results_checked),
		.empty_hits(empty_hits),
		.not_found_hits(not_found_hits),
		.full_hits(full_hits)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic offer_request(input cmd_t c, input data_t v, input pos_t p);
		cmd_ch.valid <= 1'b1;
		cmd_ch.command <= c;
		cmd_ch.value <= v;
		cmd_ch.position <= p;
		do @(posedge clk); while (!cmd_ch.ready);
		requests_sent++;
	endtask

	task automatic idle_sender(input int cycles);
		if (cycles > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic pause_until_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
	endtask

	task automatic send_random(input traffic_mode_t mode, output bit counted);
		int roll;
		int append_pct;
		cmd_t c;
		data_t v;
		pos_t p;
		v = data_t'($urandom);
		if ($urandom_range(0, 7) == 0) begin
			case ($urandom_range(0, 3))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = '0;
				default: v = '1;
			endcase
		end
		p = pos_t'($urandom_range(0, CAPACITY + 1));
		if ($urandom_range(0, 3) == 0)
			p = pos_t'($urandom_range(0, (1 << POS_W) - 1));
		case (mode)
			MODE_FILL: append_pct = 80;
			MODE_MIX: append_pct = 45;
			default: append_pct = 15;
		endcase
		roll = $urandom_range(0, 99);
		counted = 1'b1;
		if ($urandom_range(0, 19) == 0) begin
			c = cmd_t'($urandom_range(FIRST_UNUSED_CMD, LAST_CMD));
			counted = 1'b0;
			ignored_sent++;
		end else if (roll < append_pct) begin
			c = CMD_APPEND;
		end else if (roll < append_pct + 10) begin
			c = CMD_READ_ALL;
		end else begin
			case ($urandom_range(0, 2))
				0: c = CMD_DEL_HEAD;
				1: c = CMD_DEL_TAIL;
				default: c = CMD_DEL_POS;
			endcase
		end
		offer_request(c, v, p);
	endtask

	// watchdog: ends the run when nothing moves for too long
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results outstanding", idle_cycles,
					open_count);
				$display("bounded_list_with_positional_delete: mismatch");
				$finish;
			end
		end
	end

	// result side stalls
	initial begin
		int mode_left;
		rx_mode_t rx_mode;
		rsp_ch.ready <= 1'b0;
		holds_done = 0;
		mode_left = 0;
		rx_mode = RX_OPEN;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(10, 60);
				end
				mode_left--;
				case (rx_mode)
					RX_OPEN: rsp_ch.ready <= 1'b1;
					RX_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		int burst_left;
		int gap;
		int done_in_round;
		bit counted;
		arst_n <= 1'b0;
		end_check <= 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.command <= CMD_APPEND;
		cmd_ch.value <= '0;
		cmd_ch.position <= '0;
		requests_sent = 0;
		ignored_sent = 0;
		hold_requests = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list on every read and delete command
		offer_request(CMD_READ_ALL, '0, '0);
		offer_request(CMD_DEL_HEAD, '0, '0);
		offer_request(CMD_DEL_TAIL, '0, '0);
		offer_request(CMD_DEL_POS, '0, '1);
		// value extremes
		offer_request(CMD_APPEND, 32'h7FFF_FFFF, '0);
		offer_request(CMD_APPEND, 32'h8000_0000, '1);
		offer_request(CMD_APPEND, '0, '0);
		offer_request(CMD_APPEND, '1, '0);
		offer_request(CMD_READ_ALL, '0, '0);
		// positions not held: far beyond and just past the tail
		offer_request(CMD_DEL_POS, '0, '1);
		offer_request(CMD_DEL_POS, '0, pos_t'(4));
		// middle delete closes the gap
		offer_request(CMD_DEL_POS, '0, pos_t'(1));
		offer_request(CMD_DEL_HEAD, '0, '0);
		offer_request(CMD_DEL_TAIL, '0, '0);
		offer_request(CMD_READ_ALL, '0, '0);
		// unused commands are dropped
		for (int k = FIRST_UNUSED_CMD; k <= LAST_CMD; k++) begin
			offer_request(cmd_t'(k), data_t'($urandom), pos_t'($urandom));
			ignored_sent++;
		end
		offer_request(CMD_DEL_POS, '0, '0);
		offer_request(CMD_READ_ALL, '0, '0);
		pause_until_drained();

		for (int r = 0; r < ROUNDS; r++) begin
			if (r == 2 || r == 5)
				pause_until_drained();
			if (r == 3)
				hold_requests++;
			done_in_round = 0;
			burst_left = $urandom_range(1, 12);
			while (done_in_round < ROUND_ITEMS) begin
				send_random(traffic_mode_t'(r % 3), counted);
				if (counted)
					done_in_round++;
				burst_left--;
				if (burst_left == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
					idle_sender(gap);
					burst_left = $urandom_range(1, 12);
				end
			end
		end

		pause_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		end_check <= 1'b1;
		repeat (2) @(posedge clk);

		$display("run covered %0d requests (%0d with unused commands), %0d results checked",
			requests_sent, ignored_sent, results_checked);
		$display("status outcomes seen: empty %0d, position not found %0d, full %0d", empty_hits,
			not_found_hits, full_hits);
		if (fail_count == 0) begin
			$display("bounded_list_with_positional_delete: match");
		end else begin
			$display("bounded_list_with_positional_delete: mismatch");
		end
		$finish;
	end
endmodule

### files.f
+incdir+src
src/blpd_pkg.sv
src/blpd_cmd_if.sv
src/blpd_rsp_if.sv
src/blpd_cell.sv
src/bounded_list_with_positional_delete.sv
test/bounded_list_with_positional_delete_checker.sv
test/bounded_list_with_positional_delete_tb.sv
